FILE: rtl/quoted_word_tokenizer_defines.svh
// assertion macros for the quoted word tokenizer checker
// needs i_clk and i_rst_n in the scope of each use
`ifndef QUOTED_WORD_TOKENIZER_DEFINES_SVH
`define QUOTED_WORD_TOKENIZER_DEFINES_SVH

// implication checked in the same cycle
`define QWT_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("qwt check failed");

// implication checked in the next cycle
`define QWT_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("qwt check failed");

`endif

FILE: rtl/qwt_pkg.sv
// shared types and constants for the quoted word tokenizer
// no dependencies
package qwt_pkg;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_CHAR = 2'd0;
    localparam t_kind KIND_END  = 2'd1;
    localparam t_kind KIND_OK   = 2'd2;
    localparam t_kind KIND_ERR  = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

FILE: rtl/quoted_word_tokenizer.sv
// Usage notes for quoted_word_tokenizer
// Input channel: one byte of a command line per beat (i_in_valid, o_in_stall,
// i_in_byte); a zero byte ends the line.
// Output channel: result beats (o_out_valid, i_out_stall, o_kind, o_out_byte,
// o_last). A byte gives zero, one or two results; o_last marks the final one.
// Kinds: token character, token end, line ok, line error.
// Path: an accepted byte waits in the input register, and its first result is
// registered in the output register.
// Throughput: one byte per cycle while each byte gives at most one result and
// the output is not stalled; a byte that closes a word at end of line holds off
// the next byte until the single output register drains the line-ok result.
// The input register and the output register separate the two sides, so a new
// byte is accepted while a result waits to be taken.
// A stall on the output holds the result and backs up into o_in_stall once the
// input register is full.
// Reset (synchronous, active low) empties both registers and returns the lexer
// to the whitespace state.
// Depends on qwt_pkg.
module quoted_word_tokenizer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_in_byte,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output qwt_pkg::t_kind      o_kind,
    output logic [7:0]          o_out_byte,
    output logic                o_last
);

    localparam logic [2:0] MODE_SPACE = 3'd0;
    localparam logic [2:0] MODE_WORD  = 3'd1;
    localparam logic [2:0] MODE_QUOTE = 3'd2;
    localparam logic [2:0] MODE_ESC   = 3'd3;
    localparam logic [2:0] MODE_QESC  = 3'd4;

    logic [2:0]     r_mode;
    logic [2:0]     n_mode;
    logic           r_in_valid;
    logic [7:0]     r_in_byte;
    logic           r_out_valid;
    logic           r_pend;
    qwt_pkg::t_kind r_kind;
    logic [7:0]     r_out_byte;
    logic           r_last;

    logic [1:0]     res_cnt;
    qwt_pkg::t_kind res_kind;
    logic [7:0]     res_byte;
    logic           out_fire;
    logic           out_free;
    logic           consume;

    assign out_fire = r_out_valid & ~i_out_stall;
    assign out_free = ~r_out_valid | (out_fire & ~r_pend);
    assign consume  = r_in_valid & out_free;

    assign o_in_stall  = r_in_valid & ~consume;
    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_last;

    always_comb begin
        n_mode   = r_mode;
        res_cnt  = 2'd0;
        res_kind = qwt_pkg::KIND_CHAR;
        res_byte = 8'd0;
        case (r_mode)
            MODE_WORD: begin
                if (r_in_byte == qwt_pkg::CH_NUL) begin
                    res_cnt  = 2'd2;
                    res_kind = qwt_pkg::KIND_END;
                    n_mode   = MODE_SPACE;
                end else if (qwt_pkg::is_blank(r_in_byte)) begin
                    res_cnt  = 2'd1;
                    res_kind = qwt_pkg::KIND_END;
                    n_mode   = MODE_SPACE;
                end else if (r_in_byte == qwt_pkg::CH_QUOTE) begin
                    n_mode = MODE_QUOTE;
                end else if (r_in_byte == qwt_pkg::CH_BSL) begin
                    n_mode = MODE_ESC;
                end else begin
                    res_cnt  = 2'd1;
                    res_byte = r_in_byte;
                end
            end
            MODE_QUOTE: begin
                if (r_in_byte == qwt_pkg::CH_NUL) begin
                    res_cnt  = 2'd1;
                    res_kind = qwt_pkg::KIND_ERR;
                    n_mode   = MODE_SPACE;
                end else if (r_in_byte == qwt_pkg::CH_QUOTE) begin
                    n_mode = MODE_WORD;
                end else if (r_in_byte == qwt_pkg::CH_BSL) begin
                    n_mode = MODE_QESC;
                end else begin
                    res_cnt  = 2'd1;
                    res_byte = r_in_byte;
                end
            end
            MODE_ESC, MODE_QESC: begin
                res_cnt = 2'd1;
                if (r_in_byte == qwt_pkg::CH_NUL) begin
                    res_kind = qwt_pkg::KIND_ERR;
                    n_mode   = MODE_SPACE;
                end else begin
                    res_byte = r_in_byte;
                    n_mode   = (r_mode == MODE_ESC) ? MODE_WORD : MODE_QUOTE;
                end
            end
            default: begin
                n_mode = MODE_SPACE;
                if (r_in_byte == qwt_pkg::CH_NUL) begin
                    res_cnt  = 2'd1;
                    res_kind = qwt_pkg::KIND_OK;
                end else if (r_in_byte == qwt_pkg::CH_QUOTE) begin
                    n_mode = MODE_QUOTE;
                end else if (r_in_byte == qwt_pkg::CH_BSL) begin
                    n_mode = MODE_ESC;
                end else if (!qwt_pkg::is_blank(r_in_byte)) begin
                    res_cnt  = 2'd1;
                    res_byte = r_in_byte;
                    n_mode   = MODE_WORD;
                end
            end
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_in_byte;
        end
    end

    // lexer state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SPACE;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            if (consume) begin
                r_mode <= n_mode;
            end
            if (out_fire && r_pend) begin
                r_pend <= 1'b0;
            end else if (consume && res_cnt != 2'd0) begin
                r_out_valid <= 1'b1;
                r_pend      <= (res_cnt == 2'd2);
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire && r_pend) begin
            r_kind     <= qwt_pkg::KIND_OK;
            r_out_byte <= 8'd0;
            r_last     <= 1'b1;
        end else if (consume && res_cnt != 2'd0) begin
            r_kind     <= res_kind;
            r_out_byte <= res_byte;
            r_last     <= (res_cnt == 2'd1);
        end
    end

endmodule

FILE: rtl/qwt_checker.sv
// port-level checks for quoted_word_tokenizer, bound into each of its instances
// depends on qwt_pkg and quoted_word_tokenizer_defines.svh
`include "quoted_word_tokenizer_defines.svh"

module qwt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input qwt_pkg::t_kind      o_kind,
    input logic [7:0]          o_out_byte,
    input logic                o_last
);

    logic [10:0] beat;
    logic        ok_last;
    logic        is_status;

    assign beat      = {o_kind, o_out_byte, o_last};
    assign ok_last   = (o_kind == qwt_pkg::KIND_OK) && o_last;
    assign is_status = (o_kind == qwt_pkg::KIND_OK) || (o_kind == qwt_pkg::KIND_ERR);

    // a stalled result beat holds
    `QWT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(beat))

    // a beat without last is followed at once by the closing line ok
    `QWT_ASSERT_NEXT(a_pair_follow, o_out_valid && !i_out_stall && !o_last, o_out_valid && ok_last)

    // only token characters carry a byte
    `QWT_ASSERT_NOW(a_byte_zero, o_out_valid && o_kind != qwt_pkg::KIND_CHAR, o_out_byte == 8'd0)

    // line status always closes the results of its byte
    `QWT_ASSERT_NOW(a_status_last, o_out_valid && is_status, o_last)

endmodule

bind quoted_word_tokenizer qwt_checker u_qwt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_kind      (o_kind),
    .o_out_byte  (o_out_byte),
    .o_last      (o_last)
);
